/* sv/stable_three_way_partition_core_assert.svh */
// Assertion macros used by the controller RTL of the partition core.
`ifndef STABLE_THREE_WAY_PARTITION_CORE_ASSERT_SVH
`define STABLE_THREE_WAY_PARTITION_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/stp_pkg.sv */
`default_nettype none

package stp_pkg;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_CHECK,
    ST_FLUSH
  } state_e;

  localparam logic [1:0] GrpBelow = 2'd0;
  localparam logic [1:0] GrpEqual = 2'd1;
  localparam logic [1:0] GrpAbove = 2'd2;

  function automatic logic [1:0] classify(input logic [31:0] v, input logic [31:0] p);
    logic [1:0] g;
    if ($signed(v) < $signed(p)) begin
      g = GrpBelow;
    end else if (v == p) begin
      g = GrpEqual;
    end else begin
      g = GrpAbove;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

/* sv/stp_mem.sv */
`default_nettype none

module stp_mem #(
  parameter int DEPTH = 64,
  parameter int AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [31:0]      wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [31:0]      rdata_o
);

  logic [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/stp_ctrl.sv */
`default_nettype none

module stp_ctrl
  import stp_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AddrW = 6,
  parameter int CntW  = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [31:0]      pivot_i,
  input  wire logic             s_tvalid_i,
  output logic                  s_tready_o,
  input  wire logic [31:0]      s_tdata_i,
  input  wire logic             s_tlast_i,
  output logic                  m_tvalid_o,
  input  wire logic             m_tready_i,
  output logic      [31:0]      m_tdata_o,
  output logic                  m_tlast_o,
  output logic      [1:0]       m_group_o,
  output logic                  m_ovf_o,
  output logic                  mem_we_o,
  output logic      [AddrW-1:0] mem_waddr_o,
  output logic      [31:0]      mem_wdata_o,
  output logic                  mem_re_o,
  output logic      [AddrW-1:0] mem_raddr_o,
  input  wire logic [31:0]      mem_rdata_i
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [1:0]       grp_q, grp_d;
  logic             pend_valid_q, pend_valid_d;
  logic [31:0]      pend_value_q, pend_value_d;
  logic [1:0]       pend_grp_q, pend_grp_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_value_q, out_value_d;
  logic [1:0]       out_grp_q, out_grp_d;
  logic             out_last_q, out_last_d;
  logic             out_ovf_q, out_ovf_d;

  logic       can_move, in_acc, has_room, hit, stall, idx_end;
  logic [1:0] elem_grp;

  assign can_move = !out_valid_q || m_tready_i;
  assign in_acc   = s_tvalid_i && (state_q == ST_LOAD);
  assign has_room = cnt_q < CntW'(DEPTH);
  assign elem_grp = classify(mem_rdata_i, pivot_i);
  assign hit      = (state_q == ST_CHECK) && (elem_grp == grp_q);
  // A hit can only retire the held result when the output register frees up.
  assign stall    = hit && pend_valid_q && !can_move;
  assign idx_end  = (CntW'(idx_q) + CntW'(1)) == cnt_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && s_tlast_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stall) begin
          state_d = (idx_end && grp_q == GrpAbove) ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (can_move) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cnt_d        = cnt_q;
    drop_d       = drop_q;
    idx_d        = idx_q;
    grp_d        = grp_q;
    pend_valid_d = pend_valid_q;
    pend_value_d = pend_value_q;
    pend_grp_d   = pend_grp_q;
    out_valid_d  = out_valid_q && !m_tready_i;
    out_value_d  = out_value_q;
    out_grp_d    = out_grp_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (s_tlast_i) begin
            idx_d = '0;
            grp_d = GrpBelow;
          end
        end
      end
      ST_READ: begin
      end
      ST_CHECK: begin
        if (!stall) begin
          if (hit) begin
            // The previous hit is now known not to be the final result.
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_value_d = pend_value_q;
              out_grp_d   = pend_grp_q;
              out_last_d  = 1'b0;
              out_ovf_d   = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_value_d = mem_rdata_i;
            pend_grp_d   = grp_q;
          end
          if (idx_end) begin
            idx_d = '0;
            grp_d = grp_q + 2'd1;
          end else begin
            idx_d = idx_q + AddrW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (can_move) begin
          out_valid_d  = 1'b1;
          out_value_d  = pend_value_q;
          out_grp_d    = pend_grp_q;
          out_last_d   = 1'b1;
          out_ovf_d    = drop_q;
          pend_valid_d = 1'b0;
          cnt_d        = '0;
          drop_d       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      cnt_q        <= '0;
      drop_q       <= 1'b0;
      idx_q        <= '0;
      grp_q        <= GrpBelow;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      drop_q       <= drop_d;
      idx_q        <= idx_d;
      grp_q        <= grp_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_value_q <= pend_value_d;
    pend_grp_q   <= pend_grp_d;
    out_value_q  <= out_value_d;
    out_grp_q    <= out_grp_d;
    out_last_q   <= out_last_d;
    out_ovf_q    <= out_ovf_d;
  end

  assign s_tready_o  = (state_q == ST_LOAD);
  assign m_tvalid_o  = out_valid_q;
  assign m_tdata_o   = out_value_q;
  assign m_tlast_o   = out_last_q;
  assign m_group_o   = out_grp_q;
  assign m_ovf_o     = out_ovf_q;
  assign mem_we_o    = in_acc && has_room;
  assign mem_waddr_o = cnt_q[AddrW-1:0];
  assign mem_wdata_o = s_tdata_i;
  assign mem_re_o    = (state_q == ST_READ);
  assign mem_raddr_o = idx_q;

  `include "stable_three_way_partition_core_assert.svh"

  `STP_ASSERT_IMP(a_flush_has_pending, clk_i, rst_ni,
    state_q == ST_FLUSH, pend_valid_q, "flush without a held result")
  `STP_ASSERT_IMP(a_sweep_nonempty, clk_i, rst_ni,
    state_q != ST_LOAD, cnt_q != '0, "sweep over an empty buffer")
  `STP_ASSERT_IMP(a_count_bounded, clk_i, rst_ni,
    1'b1, cnt_q <= CntW'(DEPTH), "element count beyond buffer depth")
  `STP_ASSERT_NXT(a_flush_clears, clk_i, rst_ni,
    state_q == ST_FLUSH && can_move,
    state_q == ST_LOAD && cnt_q == '0 && !drop_q && out_last_q,
    "run state not cleared after the final result")

endmodule

`default_nettype wire

/* sv/stable_three_way_partition_core.sv */
// Stable three-way partition. Values stream in on the slave side, one
// transaction per cycle, and are written into a DEPTH-entry buffer; elements
// past DEPTH are dropped and flagged. The transaction carrying tlast starts
// the emission: the buffer is swept three times (below, equal to, above the
// pivot), each sweep in arrival order, and every hit leaves on the master
// side with its group in tuser. In each sweep every stored element is first
// read from memory and then classified; the drain can stall while the master
// holds tready low, and no input is taken during the drain. The final result
// carries tlast and the overflow flag. The user must write the pivot through
// the cfg channel only while idle; the block itself does not enforce this.
`default_nettype none

module stable_three_way_partition_core #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,     // pivot
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // value
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // out_value
  output logic             m_axis_tlast,
  output logic      [2:0]  m_axis_tuser    // group [1:0], overflowed [2]
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);

  logic [31:0]      pivot_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [31:0]      mem_wdata, mem_rdata;
  logic [1:0]       group;
  logic             ovf;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q <= '0;
    end else if (cfg_valid_i) begin
      pivot_q <= cfg_data_i;
    end
  end

  stp_mem #(
    .DEPTH(DEPTH),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  stp_ctrl #(
    .DEPTH(DEPTH),
    .AddrW(AddrW),
    .CntW (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pivot_i    (pivot_q),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_group_o  (group),
    .m_ovf_o    (ovf),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  assign m_axis_tuser = {ovf, group};

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import stp_pkg::GrpBelow;
  import stp_pkg::GrpEqual;
  import stp_pkg::GrpAbove;

  localparam int BUF_DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 500;
  localparam int SETTLE = 8;
  localparam int TAIL = 40;
  localparam logic [31:0] MostNeg = 32'h8000_0000;
  localparam logic [31:0] MostPos = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  grp;
    logic        end_of_run;
    logic        overflowed;
  } part_result_t;

  // Tracks the current sequence and the partitioned results it must produce.
  class partition_checker;
    logic [31:0]  pivot;
    logic [31:0]  run_buf[$];
    bit           dropped;
    part_result_t due_results[$];
    int unsigned  errors;
    int unsigned  items;
    int unsigned  runs;
    int unsigned  overflow_runs;
    int unsigned  matched;
    int unsigned  pivot_writes;

    function new();
      pivot = '0;
      dropped = 1'b0;
      errors = 0;
      items = 0;
      runs = 0;
      overflow_runs = 0;
      matched = 0;
      pivot_writes = 0;
    endfunction

    function logic [1:0] group_of(logic [31:0] v);
      if ($signed(v) < $signed(pivot)) return GrpBelow;
      return (v == pivot) ? GrpEqual : GrpAbove;
    endfunction

    function void take_value(logic [31:0] v, logic last);
      logic [1:0] sweep [3];
      int         tail_idx;
      sweep[0] = GrpBelow;
      sweep[1] = GrpEqual;
      sweep[2] = GrpAbove;
      items++;
      if (run_buf.size() < BUF_DEPTH) begin
        run_buf.push_back(v);
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      runs++;
      if (dropped) overflow_runs++;
      // Three sweeps over the buffer keep arrival order inside each group.
      foreach (sweep[g]) begin
        foreach (run_buf[i]) begin
          if (group_of(run_buf[i]) == sweep[g]) begin
            due_results.push_back('{run_buf[i], sweep[g], 1'b0, 1'b0});
          end
        end
      end
      tail_idx = due_results.size() - 1;
      due_results[tail_idx].end_of_run = 1'b1;
      due_results[tail_idx].overflowed = dropped;
      run_buf.delete();
      dropped = 1'b0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task match_result(logic [31:0] data, logic [2:0] user, logic last);
      part_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %h arrived with nothing pending", data));
        return;
      end
      want = due_results.pop_front();
      matched++;
      if (data !== want.value)
        report($sformatf("value %h, wanted %h", data, want.value));
      if (user[1:0] !== want.grp)
        report($sformatf("group %0d for %h, wanted %0d", user[1:0], data, want.grp));
      if (user[2] !== want.overflowed)
        report($sformatf("overflow flag %b for %h, wanted %b", user[2], data,
                         want.overflowed));
      if (last !== want.end_of_run)
        report($sformatf("tlast %b for %h, wanted %b", last, data, want.end_of_run));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;

  bit          steady = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned cycle_count = 0;

  partition_checker chk = new();

  stable_three_way_partition_core #(
    .DEPTH(BUF_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic int idle_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values cluster around the pivot so that all three groups stay busy.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return chk.pivot;
      2: return chk.pivot + 32'($urandom_range(0, 6)) - 32'd3;
      3: return ($urandom_range(0, 1) != 0) ? MostNeg : MostPos;
      default: return $urandom();
    endcase
  endfunction

  // A gap of zero leaves tvalid high, so the caller must follow with another item.
  task automatic push_item(input logic [31:0] v, input logic last, input int gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    chk.take_value(v, last);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic push_run(input logic [31:0] vals[$], input bit close);
    int gap;
    foreach (vals[i]) begin
      gap = idle_gap();
      if (close && i == vals.size() - 1 && gap == 0) gap = 1;
      push_item(vals[i], i == vals.size() - 1, gap);
    end
  endtask

  task automatic random_runs(input int budget);
    logic [31:0] vals[$];
    int          len;
    while (budget > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      vals.delete();
      repeat (len) vals.push_back(pick_value());
      push_run(vals, budget <= len);
      budget -= len;
    end
  endtask

  // The pivot only changes once the previous sequence has fully drained.
  task automatic write_pivot(input logic [31:0] p);
    while (chk.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= p;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    chk.pivot = p;
    chk.pivot_writes++;
  endtask

  initial begin
    int          stall_left;
    logic        ready_next;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        chk.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      end
      ready_next = (stall_left == 0);
      if (stall_left > 0) stall_left--;
      m_axis_tready <= ready_next;
    end
  end

  initial begin
    logic [31:0] vals[$];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes and all three groups against the reset pivot, then a lone element.
    push_run({MostNeg, 32'hFFFF_FFFF, 32'd0, 32'd1, MostPos, 32'd0, 32'hFFFF_FFFF}, 1'b0);
    push_run({32'd5}, 1'b1);
    write_pivot(MostNeg);
    push_run({MostNeg, 32'd3, MostNeg}, 1'b1);
    write_pivot(MostPos);
    push_run({MostPos, 32'd0, 32'hFFFF_FFFB, MostPos}, 1'b1);

    write_pivot($urandom());
    random_runs(6);

    steady = 1'b1;
    write_pivot($urandom_range(0, 15));
    random_runs(5);
    steady = 1'b0;

    // Hold the output off while a full buffer drains and the next run waits.
    write_pivot($urandom());
    long_hold_req = 1'b1;
    vals.delete();
    repeat (BUF_DEPTH) vals.push_back(pick_value());
    push_run(vals, 1'b0);
    random_runs(3);

    // Two elements past the buffer depth, the marked one among the dropped.
    write_pivot($urandom());
    vals.delete();
    repeat (BUF_DEPTH + 2) vals.push_back(pick_value());
    push_run(vals, 1'b1);

    write_pivot($urandom());
    random_runs(6);

    while (chk.due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    $display("tb_top: %0d values in %0d runs, %0d of them over depth, %0d results compared",
             chk.items, chk.runs, chk.overflow_runs, chk.matched);
    $display("tb_top: %0d pivot settings incl. both extremes, output held off once",
             chk.pivot_writes);
    if (chk.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
